@@ sv/lvps_pkg.sv @@
package lvps_pkg;

    // default string length limit and stack depth
    localparam int MAX_LEN_DEF = 1024;

    // request and result field widths
    localparam int CH_W      = 8;
    localparam int LONGEST_W = 11;
    localparam int OUT_TDATA_W = 16;

    // the one character that opens a bracket
    localparam logic [CH_W-1:0] OPEN_CHAR = 8'h28;

    // operation applied to the whole row of stack cells in the same cycle
    typedef struct packed {
        logic push;
        logic pop;
    } t_stack_op;

endpackage

@@ sv/lvps_cell.sv @@
module lvps_cell
    import lvps_pkg::*;
#(
    parameter int ENT_W = 12
) (
    input  logic             i_clk,
    input  t_stack_op        i_op,
    input  logic [ENT_W-1:0] i_from_up,
    input  logic [ENT_W-1:0] i_from_down,
    output logic [ENT_W-1:0] o_ent
);

    logic [ENT_W-1:0] r_ent;

    // push takes the entry above, pop takes the entry below
    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_ent <= i_from_up;
        end else if (i_op.pop) begin
            r_ent <= i_from_down;
        end
    end

    assign o_ent = r_ent;

endmodule

@@ sv/lvps_skid.sv @@
module lvps_skid
    import lvps_pkg::*;
#(
    parameter int W = 12
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);

    logic         r_out_v;
    logic [W-1:0] r_out_d;
    logic         r_skid_v;
    logic [W-1:0] r_skid_d;
    logic         out_free;

    assign o_ready  = !r_skid_v;
    assign out_free = !r_out_v || i_ready;

    // control: output slot and spare slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            r_out_v  <= r_skid_v || i_valid;
            r_skid_v <= 1'b0;
        end else if (i_valid && !r_skid_v) begin
            r_skid_v <= 1'b1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_d <= r_skid_v ? r_skid_d : i_data;
        end else if (i_valid && !r_skid_v) begin
            r_skid_d <= i_data;
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out_d;

endmodule

@@ sv/longest_valid_paren_stack_unit.sv @@
// longest valid bracket substring, one character per request
// result: registered in the output register when the request is taken, or in the spare register while the output stalls
// throughput: one request per cycle while the output accepts; the stack is a row of cells that all shift
//   by one entry in the same cycle, with the top two cells read directly
// reset (i_rst_n low, synchronous): stack count, position, best length, overflow
//   flag and output handshake clear; stack cell contents are left as they are
module longest_valid_paren_stack_unit
    import lvps_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [CH_W-1:0]        i_s_axis_tdata,   // [7:0] ch
    input  logic                   i_s_axis_tlast,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // [10:0] longest, rest zero
    output logic                   o_m_axis_tuser    // [0] overflow
);

    localparam int PW    = $clog2(MAX_LEN + 1);
    localparam int ENT_W = PW + 1;
    localparam int RES_W = LONGEST_W + 1;

    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_count;
    logic [PW-1:0] r_best;
    logic          r_ovf;

    logic [PW-1:0] n_pos;
    logic [PW-1:0] n_count;
    logic [PW-1:0] n_best;
    logic          n_ovf;

    logic [ENT_W-1:0] ent [MAX_LEN];
    logic [ENT_W-1:0] new_ent;
    t_stack_op        op;

    logic             accept;
    logic             skid_ready;
    logic             too_long;
    logic             is_open;
    logic             top_open;
    logic             take;
    logic [PW-1:0]    len;
    logic [PW-1:0]    best_now;
    logic [RES_W-1:0] res;
    logic [RES_W-1:0] res_out;

    assign o_s_axis_tready = skid_ready;
    assign accept = i_s_axis_tvalid && skid_ready;

    // decode the character against the top of the stack
    assign too_long = r_ovf || (r_pos >= PW'(MAX_LEN));
    assign is_open  = (i_s_axis_tdata == OPEN_CHAR);
    assign top_open = (r_count != '0) && ent[0][PW];
    assign take     = accept && !too_long;
    assign new_ent  = {is_open, r_pos};

    always_comb begin
        op.push = take && (is_open || !top_open) && (r_count < PW'(MAX_LEN));
        op.pop  = take && !is_open && top_open;
    end

    // matched length: to the entry below the popped open, or from string start
    always_comb begin
        if (r_count >= PW'(2)) begin
            len = r_pos - ent[1][PW-1:0];
        end else begin
            len = r_pos + PW'(1);
        end
        best_now = (op.pop && (len > r_best)) ? len : r_best;
    end

    // next state, cleared after the last character of a string
    always_comb begin
        n_pos   = r_pos;
        n_count = r_count;
        n_best  = r_best;
        n_ovf   = r_ovf;
        if (accept) begin
            if (i_s_axis_tlast) begin
                n_pos   = '0;
                n_count = '0;
                n_best  = '0;
                n_ovf   = 1'b0;
            end else begin
                n_ovf  = too_long;
                n_best = best_now;
                if (take) begin
                    n_pos = r_pos + PW'(1);
                end
                if (op.push) begin
                    n_count = r_count + PW'(1);
                end else if (op.pop) begin
                    n_count = r_count - PW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_best  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_best  <= n_best;
            r_ovf   <= n_ovf;
        end
    end

    // row of stack cells, cell 0 is the top
    for (genvar gi = 0; gi < MAX_LEN; gi++) begin : g_cell
        logic [ENT_W-1:0] from_up;
        logic [ENT_W-1:0] from_down;
        if (gi == 0) begin : g_top
            assign from_up = new_ent;
        end else begin : g_mid
            assign from_up = ent[gi-1];
        end
        if (gi == MAX_LEN - 1) begin : g_bot
            assign from_down = '0;
        end else begin : g_inner
            assign from_down = ent[gi+1];
        end
        lvps_cell #(
            .ENT_W(ENT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_op       (op),
            .i_from_up  (from_up),
            .i_from_down(from_down),
            .o_ent      (ent[gi])
        );
    end

    // result goes through the output register pair
    assign res = {too_long, LONGEST_W'(best_now)};

    lvps_skid #(
        .W(RES_W)
    ) u_skid (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .o_ready(skid_ready),
        .i_data (res),
        .o_valid(o_m_axis_tvalid),
        .i_ready(i_m_axis_tready),
        .o_data (res_out)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'(res_out[LONGEST_W-1:0]);
    assign o_m_axis_tuser = res_out[LONGEST_W];

endmodule
